// ===== design/bip_pkg.sv =====
package bip_pkg;

    // Number of perceptron inputs (one lane each).
    localparam int NUM_INPUTS  = 32;

    // Field widths fixed by the interface.
    localparam int FEAT_W      = 32;
    localparam int WEIGHT_W    = 16;
    localparam int SCORE_W     = 21;
    localparam int RATE_W      = 15;

    // Adder tree geometry, padded to a power of two.
    localparam int TREE_LEVELS = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 0;
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;

    // Configuration register map.
    localparam int              APB_ADDR_W        = 2;
    localparam int              APB_DATA_W        = 32;
    localparam [APB_ADDR_W-1:0] ADDR_LEARNING_RATE = 2'd0;
    localparam [RATE_W-1:0]     RATE_RESET        = 15'd256;

    // Weight type in Q8.8, score type in Q13.8.
    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic signed [SCORE_W-1:0]  t_score;
    typedef t_weight                    t_terms [NUM_INPUTS];

    // Update command broadcast to all lanes.
    typedef struct packed {
        logic    en;
        t_weight step;
    } t_upd_ctl;

    // One result item as it sits in the output stage.
    typedef struct packed {
        logic   updated;
        t_score score;
        logic   prediction;
    } t_result;

    // Clamp a 17-bit signed sum to the 16-bit signed range.
    function automatic t_weight sat16(input logic signed [WEIGHT_W:0] v);
        t_weight r;
        if (v[WEIGHT_W] != v[WEIGHT_W-1]) begin
            r = v[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            r = v[WEIGHT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/bip_lane.sv =====
module bip_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_feature,
    input  bip_pkg::t_upd_ctl i_upd,
    output bip_pkg::t_weight  o_term
);
    import bip_pkg::*;

    t_weight r_weight;
    t_weight n_weight;

    // Saturating step on the stored weight.
    always_comb begin
        n_weight = sat16({r_weight[WEIGHT_W-1], r_weight} + {i_upd.step[WEIGHT_W-1], i_upd.step});
    end

    // The weight moves only when this feature was active on a mispredicted train item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_upd.en && i_feature) begin
            r_weight <= n_weight;
        end
    end

    // An inactive feature contributes nothing to the score.
    assign o_term = i_feature ? r_weight : '0;

endmodule

// ===== design/bip_merge.sv =====
module bip_merge (
    input  bip_pkg::t_terms  i_terms,
    input  bip_pkg::t_weight i_threshold,
    output bip_pkg::t_score  o_score,
    output logic             o_prediction
);
    import bip_pkg::*;

    t_score node [TREE_LEVELS+1][TREE_LEAVES];

    // Leaves: sign-extended lane terms, padding leaves are zero.
    for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
        if (i < NUM_INPUTS) begin : g_used
            assign node[0][i] = {{(SCORE_W-WEIGHT_W){i_terms[i][WEIGHT_W-1]}}, i_terms[i]};
        end else begin : g_pad
            assign node[0][i] = '0;
        end
    end

    // Pairwise adder tree; at most 32 terms are ever nonzero, so the sum fits.
    for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_level
        for (genvar j = 0; j < TREE_LEAVES; j++) begin : g_node
            if (j < (TREE_LEAVES >> (l + 1))) begin : g_add
                assign node[l+1][j] = node[l][2*j] + node[l][2*j+1];
            end else begin : g_idle
                assign node[l+1][j] = '0;
            end
        end
    end

    // Signed compare of the score against the sign-extended threshold.
    assign o_score      = node[TREE_LEVELS][0];
    assign o_prediction = (o_score >=
                           $signed({{(SCORE_W-WEIGHT_W){i_threshold[WEIGHT_W-1]}}, i_threshold}));

endmodule

// ===== design/binary_input_perceptron.sv =====
// Binary-input perceptron, signed Q8.8. Each input transaction carries a 32-bit feature
// vector and an expected bit in s_axis_tdata and the action in s_axis_tuser (0 predict,
// 1 predict and train). One result transaction follows each input with the prediction,
// the score before any update and an updated flag. The block takes one item per clock
// while its skid entry is empty: one lane per input holds its weight and masks it, an adder
// tree sums the lanes and the threshold compare and the weight and threshold updates all
// settle in that same cycle, so the next item already sees the trained weights. The result
// leaves through an output register backed by a skid entry, so input flow continues while
// one result waits. learning_rate lies at APB address 0 and resets to 1.0 (256).
module binary_input_perceptron (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bip_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bip_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bip_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [39:0]                      s_axis_tdata,  // features[31:0], expected[32]
    input  logic                             s_axis_tuser,  // action[0]
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata   // prediction[0], score[21:1],
                                                            // updated[22]
);
    import bip_pkg::*;

    logic [RATE_W-1:0] r_rate;
    t_weight           r_threshold;
    t_weight           n_threshold;
    logic              r_out_valid;
    logic              r_skid_valid;
    t_result           r_out;
    t_result           r_skid;
    t_result           n_result;

    logic [FEAT_W-1:0] features;
    logic              expected;
    logic              action;
    logic              in_acc;
    logic              out_fire;
    logic              cfg_wr;
    logic              mispredict;
    t_upd_ctl          upd;
    t_terms            terms;
    t_score            score;
    logic              prediction;

    assign features = s_axis_tdata[FEAT_W-1:0];
    assign expected = s_axis_tdata[FEAT_W];
    assign action   = s_axis_tuser;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_fire = r_out_valid && m_axis_tready;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LEARNING_RATE);
    assign prdata = (paddr == ADDR_LEARNING_RATE) ? {{(APB_DATA_W-RATE_W){1'b0}}, r_rate} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (cfg_wr) begin
            r_rate <= pwdata[RATE_W-1:0];
        end
    end

    // One lane per input: masked weight out, saturating update in.
    for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
        logic feat_bit;
        if (i < FEAT_W) begin : g_in
            assign feat_bit = features[i];
        end else begin : g_out
            assign feat_bit = 1'b0;
        end
        bip_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_feature (feat_bit),
            .i_upd     (upd),
            .o_term    (terms[i])
        );
    end

    bip_merge u_merge (
        .i_terms      (terms),
        .i_threshold  (r_threshold),
        .o_score      (score),
        .o_prediction (prediction)
    );

    // Training decision: step toward the expected result.
    assign mispredict = action && (expected != prediction);
    assign upd.en     = in_acc && mispredict;
    assign upd.step   = expected ? t_weight'({1'b0, r_rate}) : -t_weight'({1'b0, r_rate});

    always_comb begin
        n_threshold = sat16({r_threshold[WEIGHT_W-1], r_threshold} -
                            {upd.step[WEIGHT_W-1], upd.step});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (upd.en) begin
            r_threshold <= n_threshold;
        end
    end

    // Result assembly.
    always_comb begin
        n_result.prediction = prediction;
        n_result.score      = score;
        n_result.updated    = mispredict;
    end

    // Output register with one skid entry; ready depends only on the skid entry.
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (in_acc) begin
                    r_out <= n_result;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_acc) begin
                if (!r_out_valid) begin
                    r_out       <= n_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_result;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // A skid entry never exists without a result in the output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // Training toward 1 never raises the threshold.
    a_thr_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(upd.en) && $past(expected)) |->
            (r_threshold <= $past(r_threshold)))
        else $error("threshold rose on a train step toward 1");

    // Training toward 0 never lowers the threshold.
    a_thr_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(upd.en) && !$past(expected)) |->
            (r_threshold >= $past(r_threshold)))
        else $error("threshold fell on a train step toward 0");

    // A predict-only transaction leaves the threshold alone.
    a_thr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(in_acc) && !$past(action)) |->
            $stable(r_threshold))
        else $error("threshold changed on a predict-only transaction");

endmodule
